/* design/tsd_pkg.sv */
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the tap sequence then hold detector.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int unsigned TimeW    = 63;
  localparam int unsigned TapW     = 24;
  localparam int unsigned HoldW    = 26;
  localparam int unsigned CountW   = 3;
  localparam int unsigned CfgDataW = 26;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 8;

  localparam logic [TapW-1:0]   TapMinRst  = TapW'(50000);
  localparam logic [TapW-1:0]   TapMaxRst  = TapW'(700000);
  localparam logic [HoldW-1:0]  HoldRst    = HoldW'(3000000);
  localparam logic [HoldW-1:0]  TimeoutRst = HoldW'(12000000);
  localparam logic [CountW-1:0] TapsReqRst = CountW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CfgTapMin  = 3'd0,
    CfgTapMax  = 3'd1,
    CfgHold    = 3'd2,
    CfgTimeout = 3'd3,
    CfgTapsReq = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TapW-1:0]   tap_min_us;
    logic [TapW-1:0]   tap_max_us;
    logic [HoldW-1:0]  hold_us;
    logic [HoldW-1:0]  sequence_timeout_us;
    logic [CountW-1:0] taps_required;
  } cfg_t;

  typedef struct packed {
    logic             button_down;
    logic [TimeW-1:0] time_us;
  } poll_t;

endpackage

/* design/tsd_cfg.sv */
// ----------------------------------------------------------------------------
// tsd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tsd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tsd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tsd_pkg::CfgDataW-1:0]   cfg_data_i,
  output tsd_pkg::cfg_t                  cfg_o
);
  import tsd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTapMin:  cfg_d.tap_min_us          = cfg_data_i[TapW-1:0];
        CfgTapMax:  cfg_d.tap_max_us          = cfg_data_i[TapW-1:0];
        CfgHold:    cfg_d.hold_us             = cfg_data_i[HoldW-1:0];
        CfgTimeout: cfg_d.sequence_timeout_us = cfg_data_i[HoldW-1:0];
        CfgTapsReq: cfg_d.taps_required       = cfg_data_i[CountW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_min_us          <= TapMinRst;
      cfg_q.tap_max_us          <= TapMaxRst;
      cfg_q.hold_us             <= HoldRst;
      cfg_q.sequence_timeout_us <= TimeoutRst;
      cfg_q.taps_required       <= TapsReqRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/tsd_in_reg.sv */
// ----------------------------------------------------------------------------
// tsd_in_reg
// Input register stage: holds one button poll until the core takes it.
// ----------------------------------------------------------------------------
module tsd_in_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tsd_pkg::InDataW-1:0]   in_data_i,
  output logic                          poll_valid_o,
  input  logic                          poll_take_i,
  output tsd_pkg::poll_t                poll_o
);
  import tsd_pkg::*;

  logic  valid_q, valid_d;
  poll_t poll_q, poll_d;
  logic  load;

  assign in_ready_o = !valid_q || poll_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    poll_d  = poll_q;
    if (load) begin
      valid_d            = 1'b1;
      poll_d.time_us     = in_data_i[TimeW-1:0];
      poll_d.button_down = in_data_i[TimeW];
    end else if (poll_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    poll_q <= poll_d;
  end

  assign poll_valid_o = valid_q;
  assign poll_o       = poll_q;

endmodule

/* design/tsd_core.sv */
// ----------------------------------------------------------------------------
// tsd_core
// Tap and hold state update with the result register.
// ----------------------------------------------------------------------------
module tsd_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tsd_pkg::cfg_t                  cfg_i,
  input  logic                           poll_valid_i,
  output logic                           poll_take_o,
  input  tsd_pkg::poll_t                 poll_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tsd_pkg::OutDataW-1:0]   out_data_o
);
  import tsd_pkg::*;

  logic [TimeW-1:0]    press_start_q, press_start_d;
  logic                press_active_q, press_active_d;
  logic [TimeW-1:0]    seq_start_q, seq_start_d;
  logic                seq_active_q, seq_active_d;
  logic [CountW-1:0]   taps_q, taps_d;
  logic                armed_q, armed_d;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [TimeW:0]      seq_diff, press_diff;
  logic [TimeW-1:0]    press_base, press_el;
  logic                seq_late, is_tap, request;
  logic [CountW:0]     taps_inc;

  assign poll_take_o = poll_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    seq_diff   = {1'b0, poll_i.time_us} - {1'b0, seq_start_q};
    seq_late   = !seq_diff[TimeW] &&
                 (seq_diff[TimeW-1:0] > TimeW'(cfg_i.sequence_timeout_us));
    press_base = press_active_q ? press_start_q : poll_i.time_us;
    press_diff = {1'b0, poll_i.time_us} - {1'b0, press_base};
    press_el   = press_diff[TimeW] ? '0 : press_diff[TimeW-1:0];
    is_tap     = (press_el >= TimeW'(cfg_i.tap_min_us)) &&
                 (press_el < TimeW'(cfg_i.tap_max_us));

    press_start_d  = press_start_q;
    press_active_d = press_active_q;
    armed_d        = armed_q;
    request        = 1'b0;

    // drop an expired sequence first
    if (seq_active_q && seq_late) begin
      taps_d       = '0;
      seq_active_d = 1'b0;
      seq_start_d  = '0;
    end else begin
      taps_d       = taps_q;
      seq_active_d = seq_active_q;
      seq_start_d  = seq_start_q;
    end
    taps_inc = {1'b0, taps_d} + 1'b1;

    if (poll_i.button_down) begin
      if (!press_active_q) begin
        press_start_d  = poll_i.time_us;
        press_active_d = 1'b1;
      end
      if (taps_d == cfg_i.taps_required && press_el >= TimeW'(cfg_i.hold_us)) begin
        armed_d = 1'b1;
      end
    end else if (press_active_q) begin
      press_active_d = 1'b0;
      press_start_d  = '0;
      if (armed_q) begin
        armed_d      = 1'b0;
        request      = 1'b1;
        taps_d       = '0;
        seq_active_d = 1'b0;
        seq_start_d  = '0;
      end else if (is_tap) begin
        if (taps_d == '0) begin
          seq_start_d  = poll_i.time_us;
          seq_active_d = 1'b1;
        end
        if (taps_inc > {1'b0, cfg_i.taps_required}) begin
          taps_d       = '0;
          seq_active_d = 1'b0;
          seq_start_d  = '0;
        end else begin
          taps_d = taps_inc[CountW-1:0];
        end
      end else begin
        taps_d       = '0;
        seq_active_d = 1'b0;
        seq_start_d  = '0;
      end
    end

    out_data_d = {3'b000, armed_d, taps_d, request};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_active_q <= 1'b0;
      seq_active_q   <= 1'b0;
      taps_q         <= '0;
      armed_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (poll_take_o) begin
        press_active_q <= press_active_d;
        seq_active_q   <= seq_active_d;
        taps_q         <= taps_d;
        armed_q        <= armed_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_start_q <= '0;
      seq_start_q   <= '0;
    end else if (poll_take_o) begin
      press_start_q <= press_start_d;
      seq_start_q   <= seq_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_take_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_taps_need_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taps_q != '0) |-> seq_active_q)
    else $error("tap count held without an active sequence");

  a_req_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[0]) |-> (out_data_q[4:1] == '0))
    else $error("request issued without clearing taps and armed flag");

  a_arm_on_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(armed_q) |-> $past(poll_i.button_down) && press_active_q)
    else $error("armed flag set outside a press");

  a_press_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_take_o |=> (press_active_q == $past(poll_i.button_down)))
    else $error("press flag does not follow the button level");

endmodule

/* design/tap_sequence_then_hold_detector.sv */
// ----------------------------------------------------------------------------
// tap_sequence_then_hold_detector
// Multi-tap then long-press detector for one push button.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one button poll per request, tdata = {button_down, time_us}.
//   Master stream: one result per poll, tdata = {hold_armed, tap_count,
//   enroll_request}. Timing registers are set through the cfg write port
//   while no poll is in flight; index order: tap_min_us, tap_max_us,
//   hold_us, sequence_timeout_us, taps_required.
//   A poll is accepted into the input register and waits there while the
//   state update runs; the result register loads when the core takes the
//   poll. Throughput is one poll per cycle while the receiver is ready, as
//   the state update reads and writes the tap state in the same cycle.
//   Reset clears the tap state and loads the default timings; no output is
//   valid after reset. When the receiver stalls, the result register holds
//   its request and the input register takes one more poll if it is empty,
//   after which s_axis_tready stays low until the result is taken.
// ----------------------------------------------------------------------------
module tap_sequence_then_hold_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [62:0] time_us, [63] button_down
  input  logic [tsd_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] enroll_request, [3:1] tap_count, [4] hold_armed, [7:5] zero
  output logic [tsd_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [tsd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tsd_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tsd_pkg::*;

  cfg_t  cfg;
  poll_t poll;
  logic  poll_valid;
  logic  poll_take;

  tsd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tsd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .poll_valid_o (poll_valid),
    .poll_take_i  (poll_take),
    .poll_o       (poll)
  );

  tsd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .poll_valid_i (poll_valid),
    .poll_take_o  (poll_take),
    .poll_i       (poll),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule
